// ----- design/plb_pkg.sv -----
`timescale 1ns / 1ps
package plb_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 9;
  localparam int FRAC_W = 16;
  localparam int STEP_W = DIM_W + FRAC_W;
  localparam int POS_W  = STEP_W + 8;
  localparam int CIDX_W = 3;

  localparam logic [CIDX_W-1:0] CFG_SRC_W = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SRC_H = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DST_W = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_DST_H = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MODE  = 3'd4;

  localparam logic [DIM_W-1:0]  DIM_RESET  = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RESET = 25'h10000;
  localparam logic [STEP_W-1:0] STEP_ONE   = 25'h10000;
  localparam logic [STEP_W-1:0] HALF_PIX   = 25'h8000;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

// ----- design/plb_div.sv -----
`timescale 1ns / 1ps
module plb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [plb_pkg::DIM_W-1:0]  num,
  input  logic [plb_pkg::DIM_W-1:0]  den,
  output logic [plb_pkg::STEP_W-1:0] quo,
  output logic                       busy
);
  import plb_pkg::*;

  logic [4:0]        cnt_r;
  logic              busy_r;
  logic [DIM_W:0]    rem_r, rem_s, rem_nxt;
  logic [STEP_W-1:0] dv_r, q_r, quo_r;
  logic              qbit;

  // one quotient bit a cycle, restoring
  always_comb begin
    rem_s = {rem_r[DIM_W-1:0], dv_r[STEP_W-1]};
    qbit  = (rem_s >= {1'b0, den});
    rem_nxt = qbit ? rem_s - {1'b0, den} : rem_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      quo_r  <= STEP_RESET;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(STEP_W);
      dv_r   <= {num, {FRAC_W{1'b0}}};
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dv_r  <= {dv_r[STEP_W-2:0], 1'b0};
      q_r   <= {q_r[STEP_W-2:0], qbit};
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        quo_r  <= {q_r[STEP_W-2:0], qbit};
      end
    end
  end

  assign quo  = quo_r;
  assign busy = busy_r;
endmodule

// ----- design/plb_store.sv -----
`timescale 1ns / 1ps
module plb_store #(
  parameter int MAX_WIDTH  = plb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = plb_pkg::DEF_MAX_HEIGHT,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT)
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [RW-1:0]                       wr_row,
  input  logic [CW-1:0]                       wr_col,
  input  logic [plb_pkg::PIX_W-1:0]           wr_data,
  input  logic                                rd_en,
  input  logic [RW-1:0]                       rd_row,
  input  logic [CW-1:0]                       rd_col,
  output logic [3:0][plb_pkg::PIX_W-1:0]      rd_data
);
  import plb_pkg::*;

  localparam int RBW   = (RW > 1) ? RW - 1 : 1;
  localparam int CBW   = (CW > 1) ? CW - 1 : 1;
  localparam int DEPTH = 1 << (RBW + CBW);

  logic [RBW+CBW-1:0] waddr;
  assign waddr = {RBW'(wr_row >> 1), CBW'(wr_col >> 1)};

  // four banks by row and column parity, so a 2x2 neighbourhood reads at once
  for (genvar rp = 0; rp < 2; rp++) begin : g_row
    for (genvar cp = 0; cp < 2; cp++) begin : g_col
      logic [PIX_W-1:0] mem [DEPTH];
      logic [PIX_W-1:0] q_r;
      logic [RW:0]      rsel;
      logic [CW:0]      csel;
      logic [RBW+CBW-1:0] raddr;

      always_comb begin
        rsel  = (RW+1)'(rd_row) + ((rd_row[0] != 1'(rp)) ? (RW+1)'(1) : '0);
        csel  = (CW+1)'(rd_col) + ((rd_col[0] != 1'(cp)) ? (CW+1)'(1) : '0);
        raddr = {RBW'(rsel >> 1), CBW'(csel >> 1)};
      end

      always_ff @(posedge clk) begin
        if (wr_en && wr_row[0] == 1'(rp) && wr_col[0] == 1'(cp)) begin
          mem[waddr] <= wr_data;
        end
        if (rd_en) begin
          q_r <= mem[raddr];
        end
      end

      assign rd_data[rp*2+cp] = q_r;
    end
  end
endmodule

// ----- design/plane_bilinear_scaler_core.sv -----
`timescale 1ns / 1ps
// Bilinear / nearest scaler for one 8-bit plane. Write items (op 0) fill the frame
// store, request items (op 1) return one pixel each. After reset and while running,
// one item is taken per cycle while out_stall does not hold the output; a request
// passes the input, address, store read, row blend and column blend steps. A write
// to one of the four size registers starts the 9.16 step dividers, which produce
// one quotient bit a cycle; input also stalls while their start pulse is pending
// and while they are busy. The store is four banks split by row and column parity,
// so the 2x2 neighbourhood is read at once.
module plane_bilinear_scaler_core #(
  parameter int MAX_WIDTH  = plb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = plb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [plb_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [plb_pkg::DIM_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [7:0]                   in_src_col,
  input  logic [7:0]                   in_src_row,
  input  logic [7:0]                   in_pixel_in,
  input  logic [7:0]                   in_dst_col,
  input  logic [7:0]                   in_dst_row,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_pixel_out,
  output logic                         out_out_of_range
);
  import plb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int IW = POS_W - FRAC_W;

  logic [DIM_W-1:0] sw_r, sh_r, tw_r, th_r;
  logic             mode_r, start_r;
  logic [DIM_W-1:0] sw_c, sh_c, tw_c, th_c;
  logic [STEP_W-1:0] dx, dy, sx, sy;
  div_ctl_t         dvx, dvy;
  logic             adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= DIM_RESET; sh_r <= DIM_RESET;
      tw_r <= DIM_RESET; th_r <= DIM_RESET;
      mode_r <= 1'b0; start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_W: begin sw_r <= cfg_data; start_r <= 1'b1; end
          CFG_SRC_H: begin sh_r <= cfg_data; start_r <= 1'b1; end
          CFG_DST_W: begin tw_r <= cfg_data; start_r <= 1'b1; end
          CFG_DST_H: begin th_r <= cfg_data; start_r <= 1'b1; end
          CFG_MODE:  mode_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sw_c = (sw_r == '0) ? DIM_W'(1) : ((32'(sw_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : sw_r);
    sh_c = (sh_r == '0) ? DIM_W'(1) :
           ((32'(sh_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : sh_r);
    tw_c = (tw_r == '0) ? DIM_W'(1) : tw_r;
    th_c = (th_r == '0) ? DIM_W'(1) : th_r;
  end

  assign dvx.start = start_r;
  assign dvy.start = start_r;

  plb_div u_div_x (.clk, .rst_n, .start(dvx.start), .num(sw_c), .den(tw_c),
                   .quo(dx), .busy(dvx.busy));
  plb_div u_div_y (.clk, .rst_n, .start(dvy.start), .num(sh_c), .den(th_c),
                   .quo(dy), .busy(dvy.busy));

  assign sx = (dx >= STEP_ONE) ? (dx >> 1) - HALF_PIX : (dx >> 1);
  assign sy = (dy >= STEP_ONE) ? (dy >> 1) - HALF_PIX : (dy >> 1);

  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || start_r || dvx.busy || dvy.busy;

  // stage 1: positions
  logic             s1_v_r, s1_op_r, s1_oor_r;
  logic [7:0]       s1_sc_r, s1_sr_r, s1_pix_r;
  logic [POS_W-1:0] s1_x_r, s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid && !in_stall;
    end
    if (adv) begin
      s1_op_r  <= in_op;
      s1_sc_r  <= in_src_col;
      s1_sr_r  <= in_src_row;
      s1_pix_r <= in_pixel_in;
      s1_oor_r <= ({1'b0, in_dst_col} >= tw_c) || ({1'b0, in_dst_row} >= th_c);
      s1_x_r   <= POS_W'(sx) + POS_W'(in_dst_col) * POS_W'(dx);
      s1_y_r   <= POS_W'(sy) + POS_W'(in_dst_row) * POS_W'(dy);
    end
  end

  // stage 2: clamp, neighbour addresses, store read
  logic             wr_ok;
  logic [POS_W-1:0] maxy, yb;
  logic [IW-1:0]    yi, xi, sh_m1, sw_m1;
  logic             rdup, cdup;
  logic [RW-1:0]    r0;
  logic [CW-1:0]    c0;
  logic [3:0][PIX_W-1:0] bank_q;

  always_comb begin
    wr_ok = s1_v_r && !s1_op_r && (32'(s1_sc_r) < MAX_WIDTH) && (32'(s1_sr_r) < MAX_HEIGHT);
    maxy  = (sh_c > DIM_W'(1)) ? ((POS_W'(sh_c) - POS_W'(1)) << FRAC_W) - POS_W'(1) : '0;
    yb    = (!mode_r && s1_y_r > maxy) ? maxy : s1_y_r;
    yi    = yb[POS_W-1:FRAC_W];
    xi    = s1_x_r[POS_W-1:FRAC_W];
    sh_m1 = IW'(sh_c) - IW'(1);
    sw_m1 = IW'(sw_c) - IW'(1);
    rdup  = yi >= sh_m1;
    cdup  = xi >= sw_m1;
    r0    = rdup ? RW'(sh_m1) : RW'(yi);
    c0    = cdup ? CW'(sw_m1) : CW'(xi);
  end

  plb_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_store (
    .clk,
    .wr_en  (wr_ok && adv),
    .wr_row (RW'(s1_sr_r)),
    .wr_col (CW'(s1_sc_r)),
    .wr_data(s1_pix_r),
    .rd_en  (adv),
    .rd_row (r0),
    .rd_col (c0),
    .rd_data(bank_q)
  );

  logic        s2_v_r, s2_oor_r, s2_mode_r, s2_rp_r, s2_cp_r, s2_rd_r, s2_cd_r;
  logic [7:0]  s2_yf_r;
  logic [15:0] s2_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r && s1_op_r;
    end
    if (adv) begin
      s2_oor_r  <= s1_oor_r;
      s2_mode_r <= mode_r;
      s2_rp_r   <= r0[0];
      s2_cp_r   <= c0[0];
      s2_rd_r   <= rdup;
      s2_cd_r   <= cdup;
      s2_yf_r   <= yb[15:8];
      s2_f_r    <= s1_x_r[15:0];
    end
  end

  // stage 3: row blend
  logic [1:0]       i00;
  logic [PIX_W-1:0] p00, p10, p01, p11;
  logic [8:0]       wt0, wt1;
  logic [17:0]      suma, sumb;

  always_comb begin
    i00  = {s2_rp_r, s2_cp_r};
    p00  = bank_q[i00];
    p10  = s2_rd_r ? p00 : bank_q[i00 ^ 2'b10];
    p01  = s2_cd_r ? p00 : bank_q[i00 ^ 2'b01];
    p11  = s2_rd_r ? p01 : (s2_cd_r ? p10 : bank_q[i00 ^ 2'b11]);
    wt1  = {1'b0, s2_yf_r};
    wt0  = 9'd256 - wt1;
    suma = 18'(p00) * 18'(wt0) + 18'(p10) * 18'(wt1);
    sumb = 18'(p01) * 18'(wt0) + 18'(p11) * 18'(wt1);
  end

  logic        s3_v_r, s3_oor_r;
  logic [7:0]  s3_a_r, s3_b_r;
  logic [15:0] s3_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
    if (adv) begin
      s3_oor_r <= s2_oor_r;
      s3_f_r   <= s2_f_r;
      // nearest: both columns the same, the column blend then passes it through
      s3_a_r   <= s2_mode_r ? p00 : suma[15:8];
      s3_b_r   <= s2_mode_r ? p00 : sumb[15:8];
    end
  end

  // stage 4: column blend product
  logic signed [8:0]  diff;
  logic signed [25:0] prod;

  always_comb begin
    diff = $signed({1'b0, s3_b_r}) - $signed({1'b0, s3_a_r});
    prod = $signed({10'b0, s3_f_r}) * 26'(diff);
  end

  logic               s4_v_r, s4_oor_r;
  logic [7:0]         s4_a_r;
  logic signed [25:0] s4_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
    if (adv) begin
      s4_oor_r <= s3_oor_r;
      s4_a_r   <= s3_a_r;
      s4_p_r   <= prod;
    end
  end

  // output register
  logic signed [9:0] res;
  logic [7:0]        pix_r;
  logic              oor_r;

  assign res = $signed({2'b0, s4_a_r}) + 10'(s4_p_r >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_v_r;
    end
    if (adv) begin
      oor_r <= s4_oor_r;
      pix_r <= s4_oor_r ? 8'd0 : res[7:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = pix_r;
  assign out_out_of_range = oor_r;
endmodule

// ----- design/plb_checker.sv -----
`timescale 1ns / 1ps
module plb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_we,
  input logic [plb_pkg::CIDX_W-1:0] cfg_index,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [7:0]                 out_pixel_out,
  input logic                       out_out_of_range
);
  import plb_pkg::*;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_pixel_out == 8'd0)
    else $error("out of range item carries a pixel");

  a_size_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == CFG_SRC_W || cfg_index == CFG_SRC_H ||
               cfg_index == CFG_DST_W || cfg_index == CFG_DST_H) |=> in_stall)
    else $error("input open while step is recomputed");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out))
    else $error("stalled item changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item out of reset");
endmodule

bind plane_bilinear_scaler_core plb_checker u_plb_checker (
  .clk, .rst_n, .cfg_we, .cfg_index, .in_stall, .out_valid, .out_stall,
  .out_pixel_out, .out_out_of_range
);
